/* sv/tpc_pkg.sv */
// ----------------------------------------------------------------------------
// tpc_pkg
// Types and constants for the triangle pixel coverage test core.
// ----------------------------------------------------------------------------
`default_nettype none

package tpc_pkg;

    localparam int COORD_W   = 16;
    localparam int PIX_W     = 10;
    localparam int WSQ_W     = 10;
    localparam int ADDR_W    = 20;
    localparam int NUM_EDGES = 3;

    // exact widths of the edge arithmetic
    localparam int DIFF_W = COORD_W + 1;        // d and q
    localparam int PROD_W = 2 * DIFF_W;         // single products
    localparam int SUM_W  = PROD_W + 1;         // det, dot
    localparam int LEN_W  = PROD_W - 1;         // len2, below 2^33
    localparam int MAG_W  = 32;                 // |det| range that can pass
    localparam int SQ_W   = 2 * MAG_W;
    localparam int RHS_W  = WSQ_W + LEN_W;
    localparam int SUB_W  = 4;                  // 4 fraction bits of the width

    localparam logic [WSQ_W-1:0] EDGE_WIDTH_SQ_RST = WSQ_W'(64);

    // end vertex of each edge: v0->v1, v1->v2, v2->v0
    function automatic int edge_end(int j);
        return (j == NUM_EDGES - 1) ? 0 : j + 1;
    endfunction

    typedef struct packed {
        logic signed [COORD_W-1:0] vert0_x;
        logic signed [COORD_W-1:0] vert0_y;
        logic signed [COORD_W-1:0] vert1_x;
        logic signed [COORD_W-1:0] vert1_y;
        logic signed [COORD_W-1:0] vert2_x;
        logic signed [COORD_W-1:0] vert2_y;
        logic        [PIX_W-1:0]   pixel_x;
        logic        [PIX_W-1:0]   pixel_y;
    } tpc_in_t;

    typedef struct packed {
        logic              inside_res;
        logic              on_edge;
        logic [ADDR_W-1:0] pixel_address;
    } tpc_out_t;

endpackage

`default_nettype wire

/* sv/triangle_pixel_coverage_test_core.sv */
// ----------------------------------------------------------------------------
// triangle_pixel_coverage_test_core
// Edge-function coverage and edge-band test of one pixel against a triangle.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive item and raise start; a beat is taken at each rising
//   edge with start high and busy low. busy is always low, so one pixel test
//   can be issued every clock.
//   Result channel: done pulses for one cycle with result valid; the receiver
//   cannot stall, so each result must be taken in that cycle.
//   Throughput: one beat per clock, set by the six-stage pipeline (differences,
//   products, sums, magnitude and width product, square, compare).
//   Configuration: cfg_we with cfg_wdata writes the squared edge half-width;
//   write it only while no test is in flight.
//   Reset: rst_n clears the stage valid bits and loads edge_width_sq with 64.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_pixel_coverage_test_core
    import tpc_pkg::*;
#(
    parameter int IMAGE_WIDTH  = 1024,
    parameter int IMAGE_HEIGHT = 1024
) (
    input  wire  logic             clk,
    input  wire  logic             rst_n,
    input  wire  logic             start,
    output       logic             busy,
    input  wire  tpc_in_t          item,
    input  wire  logic             cfg_we,
    input  wire  logic [WSQ_W-1:0] cfg_wdata,
    output       logic             done,
    output       tpc_out_t         result
);

    localparam int LATENCY = 6;

    logic                      accept;
    logic [LATENCY-1:0]        valid_reg, valid_next;
    logic [WSQ_W-1:0]          wsq_reg, wsq_next;

    // stage 1: differences
    logic signed [DIFF_W-1:0]  dx_reg [NUM_EDGES], dx_next [NUM_EDGES];
    logic signed [DIFF_W-1:0]  dy_reg [NUM_EDGES], dy_next [NUM_EDGES];
    logic signed [DIFF_W-1:0]  qx_reg [NUM_EDGES], qx_next [NUM_EDGES];
    logic signed [DIFF_W-1:0]  qy_reg [NUM_EDGES], qy_next [NUM_EDGES];
    logic [ADDR_W-1:0]         row1_reg, row1_next;
    logic [PIX_W-1:0]          x1_reg;

    // stage 2: products
    logic signed [PROD_W-1:0]  qxdy_reg [NUM_EDGES], qxdy_next [NUM_EDGES];
    logic signed [PROD_W-1:0]  qydx_reg [NUM_EDGES], qydx_next [NUM_EDGES];
    logic signed [PROD_W-1:0]  qxdx_reg [NUM_EDGES], qxdx_next [NUM_EDGES];
    logic signed [PROD_W-1:0]  qydy_reg [NUM_EDGES], qydy_next [NUM_EDGES];
    logic signed [PROD_W-1:0]  dxdx_reg [NUM_EDGES], dxdx_next [NUM_EDGES];
    logic signed [PROD_W-1:0]  dydy_reg [NUM_EDGES], dydy_next [NUM_EDGES];
    logic [ADDR_W-1:0]         rowm2_reg, rowm2_next;
    logic [PIX_W-1:0]          x2_reg;

    // stage 3: det, dot, len2
    logic signed [SUM_W-1:0]   det_reg [NUM_EDGES], det_next [NUM_EDGES];
    logic signed [SUM_W-1:0]   dot_reg [NUM_EDGES], dot_next [NUM_EDGES];
    logic [LEN_W-1:0]          len2_reg [NUM_EDGES], len2_next [NUM_EDGES];
    logic [ADDR_W-1:0]         addr3_reg, addr3_next;

    // stage 4: signs, range flags, magnitude, width product
    logic [NUM_EDGES-1:0]      pos4_reg, pos4_next, neg4_reg, neg4_next;
    logic [NUM_EDGES-1:0]      ok4_reg, ok4_next;
    logic [MAG_W-1:0]          mag4_reg [NUM_EDGES], mag4_next [NUM_EDGES];
    logic [RHS_W-1:0]          rhs4_reg [NUM_EDGES], rhs4_next [NUM_EDGES];
    logic [ADDR_W-1:0]         addr4_reg;

    // stage 5: squared distance
    logic                      inside5_reg, inside5_next;
    logic [NUM_EDGES-1:0]      ok5_reg;
    logic [SQ_W-1:0]           sq5_reg [NUM_EDGES], sq5_next [NUM_EDGES];
    logic [RHS_W-1:0]          rhs5_reg [NUM_EDGES];
    logic [ADDR_W-1:0]         addr5_reg;

    // stage 6: result
    tpc_out_t                  result_reg, result_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign done   = valid_reg[LATENCY-1];
    assign result = result_reg;

    always_comb
    begin
        logic signed [DIFF_W-1:0] vx [NUM_EDGES];
        logic signed [DIFF_W-1:0] vy [NUM_EDGES];
        logic signed [DIFF_W-1:0] px, py;
        logic [NUM_EDGES-1:0]     hit;
        logic [SUM_W-1:0]         mag;

        valid_next = {valid_reg[LATENCY-2:0], accept};
        wsq_next   = cfg_we ? cfg_wdata : wsq_reg;

        vx[0] = DIFF_W'(item.vert0_x);
        vy[0] = DIFF_W'(item.vert0_y);
        vx[1] = DIFF_W'(item.vert1_x);
        vy[1] = DIFF_W'(item.vert1_y);
        vx[2] = DIFF_W'(item.vert2_x);
        vy[2] = DIFF_W'(item.vert2_y);
        // pixel center: p*16 + 8
        px = $signed({3'b000, item.pixel_x, 4'b1000});
        py = $signed({3'b000, item.pixel_y, 4'b1000});

        for (int j = 0; j < NUM_EDGES; j++)
        begin
            dx_next[j] = vx[edge_end(j)] - vx[j];
            dy_next[j] = vy[edge_end(j)] - vy[j];
            qx_next[j] = px - vx[j];
            qy_next[j] = py - vy[j];

            qxdy_next[j] = PROD_W'(qx_reg[j]) * PROD_W'(dy_reg[j]);
            qydx_next[j] = PROD_W'(qy_reg[j]) * PROD_W'(dx_reg[j]);
            qxdx_next[j] = PROD_W'(qx_reg[j]) * PROD_W'(dx_reg[j]);
            qydy_next[j] = PROD_W'(qy_reg[j]) * PROD_W'(dy_reg[j]);
            dxdx_next[j] = PROD_W'(dx_reg[j]) * PROD_W'(dx_reg[j]);
            dydy_next[j] = PROD_W'(dy_reg[j]) * PROD_W'(dy_reg[j]);

            det_next[j]  = SUM_W'(qxdy_reg[j]) - SUM_W'(qydx_reg[j]);
            dot_next[j]  = SUM_W'(qxdx_reg[j]) + SUM_W'(qydy_reg[j]);
            len2_next[j] = LEN_W'(dxdx_reg[j]) + LEN_W'(dydy_reg[j]);

            pos4_next[j] = !det_reg[j][SUM_W-1] && (det_reg[j] != '0);
            neg4_next[j] = det_reg[j][SUM_W-1];
            mag          = det_reg[j][SUM_W-1] ? SUM_W'(-det_reg[j])
                                               : SUM_W'(det_reg[j]);
            mag4_next[j] = mag[MAG_W-1:0];
            ok4_next[j]  = (mag[SUM_W-1:MAG_W] == '0)
                        && !dot_reg[j][SUM_W-1]
                        && ($unsigned(dot_reg[j]) <= SUM_W'(len2_reg[j]));
            rhs4_next[j] = RHS_W'(wsq_reg) * RHS_W'(len2_reg[j]);

            sq5_next[j]  = SQ_W'(mag4_reg[j]) * SQ_W'(mag4_reg[j]);

            hit[j] = ok5_reg[j] && (sq5_reg[j] <= SQ_W'({rhs5_reg[j], {SUB_W{1'b0}}}));
        end

        // flipped raster address, modulo 2^ADDR_W
        row1_next  = ADDR_W'(IMAGE_HEIGHT - 1) - ADDR_W'(item.pixel_y);
        rowm2_next = ADDR_W'(row1_reg * ADDR_W'(IMAGE_WIDTH));
        addr3_next = rowm2_reg + ADDR_W'(x2_reg);

        // inside unless both signs appear
        inside5_next = !((|pos4_reg) && (|neg4_reg));

        result_next.inside_res    = inside5_reg;
        result_next.on_edge       = inside5_reg && (|hit);
        result_next.pixel_address = addr5_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            wsq_reg   <= EDGE_WIDTH_SQ_RST;
        end
        else
        begin
            valid_reg <= valid_next;
            wsq_reg   <= wsq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NUM_EDGES; j++)
        begin
            dx_reg[j]   <= dx_next[j];
            dy_reg[j]   <= dy_next[j];
            qx_reg[j]   <= qx_next[j];
            qy_reg[j]   <= qy_next[j];
            qxdy_reg[j] <= qxdy_next[j];
            qydx_reg[j] <= qydx_next[j];
            qxdx_reg[j] <= qxdx_next[j];
            qydy_reg[j] <= qydy_next[j];
            dxdx_reg[j] <= dxdx_next[j];
            dydy_reg[j] <= dydy_next[j];
            det_reg[j]  <= det_next[j];
            dot_reg[j]  <= dot_next[j];
            len2_reg[j] <= len2_next[j];
            mag4_reg[j] <= mag4_next[j];
            rhs4_reg[j] <= rhs4_next[j];
            sq5_reg[j]  <= sq5_next[j];
            rhs5_reg[j] <= rhs4_reg[j];
        end
        row1_reg    <= row1_next;
        x1_reg      <= item.pixel_x;
        rowm2_reg   <= rowm2_next;
        x2_reg      <= x1_reg;
        addr3_reg   <= addr3_next;
        pos4_reg    <= pos4_next;
        neg4_reg    <= neg4_next;
        ok4_reg     <= ok4_next;
        addr4_reg   <= addr3_reg;
        inside5_reg <= inside5_next;
        ok5_reg     <= ok4_reg;
        addr5_reg   <= addr4_reg;
        result_reg  <= result_next;
    end

    // every accepted beat gives exactly one result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted beat produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without an accepted beat");

    a_edge_implies_inside: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!result.on_edge || result.inside_res))
        else $error("edge flag set on an outside pixel");

endmodule

`default_nettype wire
